// File: hdl/vma_pkg.sv
// shared types and constants for the vector moving average
`timescale 1ns / 1ps
`default_nettype none

package vma_pkg;

  localparam int LANES    = 8;
  localparam int SAMPLE_W = 32;
  localparam int CNT_W    = 7;

  localparam logic [CNT_W-1:0] WINDOW_RESET = 7'd50;

  // two quotient bits per divide step
  localparam int DIV_STEPS = SAMPLE_W / 2;
  localparam int STEP_W    = $clog2(DIV_STEPS);

  typedef logic [LANES-1:0][SAMPLE_W-1:0] sample_vec_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FETCH,
    ST_ACCUM,
    ST_LOAD,
    ST_DIVIDE,
    ST_FINISH
  } vma_state_t;

  typedef struct packed {
    logic capture;
    logic fetch;
    logic accum;
    logic load;
    logic div_step;
    logic finish;
  } vma_cmd_t;

endpackage

`default_nettype wire

// File: hdl/vector_moving_average.sv
// top level of the eight-lane boxcar moving average
//
// Each input beat carries eight signed Q16.16 samples; each output beat carries the
// per-lane mean of the last window_length beats (sum over the count held, truncated
// toward zero) and the count held. One beat is worked at a time: the next beat is
// accepted only after the current one finishes, and finishing waits until the
// previous result has been taken. The steps are: read the oldest ring row, form the
// lane deltas, update the sums, load the dividers, run the per-lane restoring
// dividers at two quotient bits a cycle, and load the output register. The ring is
// one memory row per window slot, read and written once per beat. Writing cfg_wdata
// clears the count and the sums; the ring needs no clearing pass because a slot's
// stored row is only used after it was written.
`timescale 1ns / 1ps
`default_nettype none

module vector_moving_average #(
  parameter int MAX_WINDOW = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [6:0]  cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] in_sample_0,
  input  logic [31:0] in_sample_1,
  input  logic [31:0] in_sample_2,
  input  logic [31:0] in_sample_3,
  input  logic [31:0] in_sample_4,
  input  logic [31:0] in_sample_5,
  input  logic [31:0] in_sample_6,
  input  logic [31:0] in_sample_7,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_average_0,
  output logic [31:0] out_average_1,
  output logic [31:0] out_average_2,
  output logic [31:0] out_average_3,
  output logic [31:0] out_average_4,
  output logic [31:0] out_average_5,
  output logic [31:0] out_average_6,
  output logic [31:0] out_average_7,
  output logic [6:0]  out_samples_held
);
  import vma_pkg::*;

  localparam int HELD_MAX = (MAX_WINDOW > 127) ? 127 : MAX_WINDOW;

  vma_cmd_t    cmd;
  sample_vec_t in_samples;
  sample_vec_t out_avg;

  assign in_samples = {in_sample_7, in_sample_6, in_sample_5, in_sample_4,
                       in_sample_3, in_sample_2, in_sample_1, in_sample_0};

  assign out_average_0 = out_avg[0];
  assign out_average_1 = out_avg[1];
  assign out_average_2 = out_avg[2];
  assign out_average_3 = out_avg[3];
  assign out_average_4 = out_avg[4];
  assign out_average_5 = out_avg[5];
  assign out_average_6 = out_avg[6];
  assign out_average_7 = out_avg[7];

  vma_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .out_ready (out_ready),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  vma_datapath #(
    .MAX_WINDOW (MAX_WINDOW)
  ) u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .cmd        (cmd),
    .in_samples (in_samples),
    .out_avg    (out_avg),
    .out_held   (out_samples_held)
  );

`ifndef SYNTHESIS
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted while a beat is in progress");

  a_held_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_samples_held != 7'd0 && out_samples_held <= 7'(HELD_MAX)))
    else $error("samples held out of range");

  a_result_not_early: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && !out_valid |=> !out_valid)
    else $error("result beat appeared before the divide finished");
`endif

endmodule

`default_nettype wire

// File: hdl/vma_ctrl.sv
// controller state machine sequencing one beat through the datapath
`timescale 1ns / 1ps
`default_nettype none

module vma_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              out_ready,
  output logic              in_ready,
  output logic              out_valid,
  output vma_pkg::vma_cmd_t cmd
);
  import vma_pkg::*;

  vma_state_t        state_r;
  vma_state_t        state_nxt;
  logic [STEP_W-1:0] step_r;
  logic [STEP_W-1:0] step_nxt;
  logic              out_valid_r;
  logic              out_valid_nxt;
  logic              out_free;

  assign out_free  = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_FETCH;
      end
      ST_FETCH:  state_nxt = ST_ACCUM;
      ST_ACCUM:  state_nxt = ST_LOAD;
      ST_LOAD:   state_nxt = ST_DIVIDE;
      ST_DIVIDE: begin
        if (step_r == STEP_W'(DIV_STEPS - 1)) state_nxt = ST_FINISH;
      end
      ST_FINISH: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
      end
      ST_FETCH:  cmd.fetch    = 1'b1;
      ST_ACCUM:  cmd.accum    = 1'b1;
      ST_LOAD:   cmd.load     = 1'b1;
      ST_DIVIDE: cmd.div_step = 1'b1;
      ST_FINISH: cmd.finish   = out_free;
      default:   cmd          = '0;
    endcase
  end

  always_comb begin
    step_nxt = (state_r == ST_DIVIDE) ? step_r + 1'b1 : '0;
    if (cmd.finish) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

`default_nettype wire

// File: hdl/vma_datapath.sv
// history ring, lane sums, window counters and per-lane dividers
`timescale 1ns / 1ps
`default_nettype none

module vma_datapath #(
  parameter int MAX_WINDOW = 64
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [vma_pkg::CNT_W-1:0]        cfg_wdata,
  input  vma_pkg::vma_cmd_t                cmd,
  input  vma_pkg::sample_vec_t             in_samples,
  output vma_pkg::sample_vec_t             out_avg,
  output logic [vma_pkg::CNT_W-1:0]        out_held
);
  import vma_pkg::*;

  localparam int AW      = $clog2(MAX_WINDOW);
  localparam int SUM_W   = SAMPLE_W + $clog2(MAX_WINDOW);
  localparam int DELTA_W = SAMPLE_W + 1;
  localparam int CNT_MAX = (1 << CNT_W) - 1;
  localparam int WIN_CAP = (MAX_WINDOW > CNT_MAX) ? CNT_MAX : MAX_WINDOW;
  localparam int CMP_W   = ((AW + 1) > CNT_W) ? (AW + 1) : CNT_W;

  sample_vec_t ring_mem [MAX_WINDOW];

  logic [CNT_W-1:0]         window_r;
  logic [CNT_W-1:0]         fill_r;
  logic [AW-1:0]            write_slot_r;
  logic [AW-1:0]            slot_r;
  logic                     full_r;
  sample_vec_t              samples_r;
  sample_vec_t              rd_data_r;
  logic signed [DELTA_W-1:0] delta_r [LANES];
  logic signed [SUM_W-1:0]  sums_r [LANES];
  logic                     neg_r [LANES];
  logic [CNT_W-1:0]         rem_r [LANES];
  logic [SAMPLE_W-1:0]      quo_r [LANES];
  logic [CNT_W-1:0]         divisor_r;
  sample_vec_t              avg_r;
  logic [CNT_W-1:0]         held_r;

  logic [CNT_W-1:0]         eff_w;
  logic [AW-1:0]            cur_slot;
  logic [CMP_W-1:0]         slot_inc;
  logic [AW-1:0]            next_slot;
  logic                     full;

  logic signed [DELTA_W-1:0] delta_nxt [LANES];
  logic [SUM_W-1:0]         mag [LANES];
  logic [CNT_W:0]           t1 [LANES];
  logic [CNT_W:0]           t2 [LANES];
  logic                     ge1 [LANES];
  logic                     ge2 [LANES];
  logic [CNT_W-1:0]         r1 [LANES];
  logic [CNT_W-1:0]         r2 [LANES];
  logic [SAMPLE_W-1:0]      q1 [LANES];
  logic [SAMPLE_W-1:0]      q2 [LANES];

  // window of zero acts as one, large windows saturate
  always_comb begin
    if (window_r == '0) begin
      eff_w = CNT_W'(1);
    end else if (window_r > CNT_W'(WIN_CAP)) begin
      eff_w = CNT_W'(WIN_CAP);
    end else begin
      eff_w = window_r;
    end
    cur_slot  = (CMP_W'(write_slot_r) >= CMP_W'(eff_w)) ? '0 : write_slot_r;
    full      = fill_r >= eff_w;
    slot_inc  = CMP_W'(slot_r) + 1'b1;
    next_slot = (slot_inc >= CMP_W'(eff_w)) ? '0 : AW'(slot_inc);
  end

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      delta_nxt[l] = DELTA_W'($signed(samples_r[l]))
                   - (full_r ? DELTA_W'($signed(rd_data_r[l])) : '0);
      mag[l] = sums_r[l][SUM_W-1] ? SUM_W'(-sums_r[l]) : SUM_W'(sums_r[l]);

      // two restoring divide steps
      t1[l]  = {rem_r[l], quo_r[l][SAMPLE_W-1]};
      ge1[l] = t1[l] >= {1'b0, divisor_r};
      r1[l]  = ge1[l] ? CNT_W'(t1[l] - {1'b0, divisor_r}) : CNT_W'(t1[l]);
      q1[l]  = {quo_r[l][SAMPLE_W-2:0], ge1[l]};
      t2[l]  = {r1[l], q1[l][SAMPLE_W-1]};
      ge2[l] = t2[l] >= {1'b0, divisor_r};
      r2[l]  = ge2[l] ? CNT_W'(t2[l] - {1'b0, divisor_r}) : CNT_W'(t2[l]);
      q2[l]  = {q1[l][SAMPLE_W-2:0], ge2[l]};
    end
  end

  // ring memory
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      rd_data_r <= ring_mem[cur_slot];
    end
    if (cmd.fetch) begin
      ring_mem[slot_r] <= samples_r;
    end
  end

  // window state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r     <= WINDOW_RESET;
      fill_r       <= '0;
      write_slot_r <= '0;
      for (int l = 0; l < LANES; l++) sums_r[l] <= '0;
    end else if (cfg_we) begin
      window_r     <= cfg_wdata;
      fill_r       <= '0;
      write_slot_r <= '0;
      for (int l = 0; l < LANES; l++) sums_r[l] <= '0;
    end else if (cmd.accum) begin
      if (!full_r) fill_r <= fill_r + 1'b1;
      write_slot_r <= next_slot;
      for (int l = 0; l < LANES; l++) sums_r[l] <= sums_r[l] + SUM_W'(delta_r[l]);
    end
  end

  // payload pipeline
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      samples_r <= in_samples;
      slot_r    <= cur_slot;
      full_r    <= full;
    end
    if (cmd.fetch) begin
      for (int l = 0; l < LANES; l++) delta_r[l] <= delta_nxt[l];
    end
    if (cmd.load) begin
      divisor_r <= fill_r;
      for (int l = 0; l < LANES; l++) begin
        neg_r[l] <= sums_r[l][SUM_W-1];
        rem_r[l] <= CNT_W'(mag[l] >> SAMPLE_W);
        quo_r[l] <= mag[l][SAMPLE_W-1:0];
      end
    end
    if (cmd.div_step) begin
      for (int l = 0; l < LANES; l++) begin
        rem_r[l] <= r2[l];
        quo_r[l] <= q2[l];
      end
    end
    if (cmd.finish) begin
      held_r <= divisor_r;
      for (int l = 0; l < LANES; l++) begin
        avg_r[l] <= neg_r[l] ? SAMPLE_W'(-quo_r[l]) : quo_r[l];
      end
    end
  end

  assign out_avg  = avg_r;
  assign out_held = held_r;

endmodule

`default_nettype wire
